// ===== src/gla_pkg.sv =====
// Package for the gated linear attention step: shared constants and types.
`timescale 1ns / 1ps
package gla_pkg;

  localparam int DIM_DEF   = 16;
  localparam int MAX_OUT   = 16;

  localparam int ELEM_W    = 16;
  localparam int IDX_W     = 4;
  localparam int GATE_W    = 17;
  localparam int SCALE_W   = 16;
  localparam int STATE_W   = 40;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 17;

  localparam logic [GATE_W-1:0]    GATE_RST  = 17'd65536;
  localparam logic [SCALE_W-1:0]   SCALE_RST = 16'd4096;

  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_GATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_SCALE = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } seq_state_t;

  // Control tag that travels with one state cell through the pipeline.
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
    logic clr;
    logic k_ok;
    logic v_ok;
  } cell_ctl_t;

endpackage

// ===== src/gla_in_if.sv =====
// Input channel interface: one element of query, key and value per transfer.
`timescale 1ns / 1ps
interface gla_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         elem_index;
  logic signed [15:0] query_elem;
  logic signed [15:0] key_elem;
  logic signed [15:0] value_elem;
  logic               last_elem;
  logic               seq_start;

  modport source(output valid, elem_index, query_elem, key_elem, value_elem, last_elem,
                 seq_start, input ready);
  modport sink(input valid, elem_index, query_elem, key_elem, value_elem, last_elem,
               seq_start, output ready);
endinterface

// ===== src/gla_out_if.sv =====
// Result channel interface: one attention output element per transfer.
`timescale 1ns / 1ps
interface gla_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         out_index;
  logic signed [31:0] out_value;
  logic               out_last;

  modport source(output valid, out_index, out_value, out_last, input ready);
  modport sink(input valid, out_index, out_value, out_last, output ready);
endinterface

// ===== src/gla_cfg_if.sv =====
// Configuration write channel interface: register index and write data.
`timescale 1ns / 1ps
interface gla_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [16:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== src/gated_linear_attention_step_top.sv =====
// Top level of the recurrent gated linear attention step for one lane.
// Each element item is taken when no update pass is running and is written into the query,
// key and value buffers. The item that carries last_elem starts an update pass that walks
// the DIM by DIM state memory one cell per cycle through its single read and write port
// and ends once the datapath pipeline has drained. A state cell is decayed, updated with
// key times value, written back and folded into its column's output sum on the way.
// Results are queued and leave at the pace of the result channel; a last element is
// accepted only once the queue from the previous token is empty, while other elements
// keep flowing. seq_start clears the state lazily: the next update pass reads it as zero,
// so no clearing pass exists.
`timescale 1ns / 1ps
module gated_linear_attention_step_top #(
  parameter int DIM = gla_pkg::DIM_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gla_in_if.sink    in_ch,
  gla_out_if.source out_ch,
  gla_cfg_if.sink   cfg_ch
);
  import gla_pkg::*;

  localparam int BUF    = (DIM < MAX_OUT) ? DIM : MAX_OUT;
  localparam int EMIT_N = BUF;
  localparam int IW     = $clog2(DIM);
  localparam int BW     = $clog2(BUF);
  localparam int SW     = $clog2(DIM * DIM);
  localparam int FW     = $clog2(EMIT_N);
  localparam int CW     = $clog2(EMIT_N + 1);

  logic [GATE_W-1:0]  gate_r;
  logic [SCALE_W-1:0] scale_r;
  logic               clr_r;
  logic               in_xfer, out_xfer, buf_we, start, busy, dp_busy, q_empty;
  cell_ctl_t          iss_ctl;
  logic [IW-1:0]      iss_j, push_j;
  logic [SW-1:0]      iss_addr, s_waddr;
  logic [BW-1:0]      row_addr, col_addr;
  logic [STATE_W-1:0] s_rd, s_wdata;
  logic [ELEM_W-1:0]  k_rd, q_rd, v_rd;
  logic               s_we, push_v;
  logic [OUT_W-1:0]   push_val;
  logic [OUT_W-1:0]   oq_mem [EMIT_N];
  logic [CW-1:0]      wr_cnt_r, rd_cnt_r;

  // Configuration registers; writes are always taken.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_r  <= GATE_RST;
      scale_r <= SCALE_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_DECAY_GATE:  gate_r  <= cfg_ch.data[GATE_W-1:0];
        CFG_QUERY_SCALE: scale_r <= cfg_ch.data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign q_empty     = (wr_cnt_r == rd_cnt_r);
  assign in_ch.ready = !busy && (!in_ch.last_elem || q_empty);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign buf_we      = in_xfer && ({1'b0, in_ch.elem_index} < 5'(BUF));
  assign start       = in_xfer && in_ch.last_elem;

  // A pending clear survives until the next update pass picks it up.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= 1'b1;
    end else if (start) begin
      clr_r <= 1'b0;
    end else if (in_xfer && in_ch.seq_start) begin
      clr_r <= 1'b1;
    end
  end

  gla_ram #(.WIDTH(ELEM_W), .DEPTH(BUF)) u_qbuf (
    .clk(clk), .we(buf_we), .waddr(in_ch.elem_index[BW-1:0]), .wdata(in_ch.query_elem),
    .raddr(row_addr), .rdata(q_rd)
  );

  gla_ram #(.WIDTH(ELEM_W), .DEPTH(BUF)) u_kbuf (
    .clk(clk), .we(buf_we), .waddr(in_ch.elem_index[BW-1:0]), .wdata(in_ch.key_elem),
    .raddr(row_addr), .rdata(k_rd)
  );

  gla_ram #(.WIDTH(ELEM_W), .DEPTH(BUF)) u_vbuf (
    .clk(clk), .we(buf_we), .waddr(in_ch.elem_index[BW-1:0]), .wdata(in_ch.value_elem),
    .raddr(col_addr), .rdata(v_rd)
  );

  gla_ram #(.WIDTH(STATE_W), .DEPTH(DIM * DIM)) u_state (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(iss_addr), .rdata(s_rd)
  );

  gla_seq #(.DIM(DIM)) u_seq (
    .clk(clk), .rst_n(rst_n), .start(start), .start_clr(clr_r || in_ch.seq_start),
    .dp_busy(dp_busy), .busy(busy), .iss_ctl(iss_ctl), .iss_j(iss_j),
    .iss_addr(iss_addr), .row_addr(row_addr), .col_addr(col_addr)
  );

  gla_dp #(.DIM(DIM)) u_dp (
    .clk(clk), .rst_n(rst_n), .gate(gate_r), .scale(scale_r), .iss_ctl(iss_ctl),
    .iss_j(iss_j), .iss_addr(iss_addr), .s_rd(s_rd), .k_rd(k_rd), .q_rd(q_rd),
    .v_rd(v_rd), .s_we(s_we), .s_waddr(s_waddr), .s_wdata(s_wdata), .push_v(push_v),
    .push_j(push_j), .push_val(push_val), .busy(dp_busy)
  );

  // Result queue: entries are filled in column order, so the column is the slot.
  always_ff @(posedge clk) begin
    if (push_v) begin
      oq_mem[push_j[FW-1:0]] <= push_val;
    end
  end

  assign out_xfer = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_cnt_r <= '0;
      rd_cnt_r <= '0;
    end else if (out_xfer && out_ch.out_last) begin
      wr_cnt_r <= '0;
      rd_cnt_r <= '0;
    end else begin
      if (push_v) begin
        wr_cnt_r <= wr_cnt_r + 1'b1;
      end
      if (out_xfer) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
    end
  end

  assign out_ch.valid     = !q_empty;
  assign out_ch.out_index = 4'(rd_cnt_r);
  assign out_ch.out_value = oq_mem[rd_cnt_r[FW-1:0]];
  assign out_ch.out_last  = (rd_cnt_r == CW'(EMIT_N - 1));

endmodule

// ===== src/gla_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module gla_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/gla_seq.sv =====
// Sequencer: walks the state matrix column by column, one cell per cycle.
`timescale 1ns / 1ps
module gla_seq #(
  parameter int DIM = gla_pkg::DIM_DEF,
  localparam int BUF = (DIM < gla_pkg::MAX_OUT) ? DIM : gla_pkg::MAX_OUT,
  localparam int IW  = $clog2(DIM),
  localparam int BW  = $clog2(BUF),
  localparam int SW  = $clog2(DIM * DIM)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              start_clr,
  input  logic              dp_busy,
  output logic              busy,
  output gla_pkg::cell_ctl_t iss_ctl,
  output logic [IW-1:0]     iss_j,
  output logic [SW-1:0]     iss_addr,
  output logic [BW-1:0]     row_addr,
  output logic [BW-1:0]     col_addr
);
  import gla_pkg::*;

  seq_state_t    state_r, state_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic [SW-1:0] addr_r, addr_nxt;
  logic          clr_r, clr_nxt;
  logic          row_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      addr_r  <= '0;
      clr_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      addr_r  <= addr_nxt;
      clr_r   <= clr_nxt;
    end
  end

  assign row_end = (i_r == IW'(DIM - 1));

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    addr_nxt  = addr_r;
    clr_nxt   = clr_r;
    iss_ctl   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          i_nxt     = '0;
          j_nxt     = '0;
          addr_nxt  = '0;
          clr_nxt   = start_clr;
        end
      end
      ST_RUN: begin
        iss_ctl.vld   = 1'b1;
        iss_ctl.first = (i_r == '0);
        iss_ctl.last  = row_end;
        iss_ctl.clr   = clr_r;
        iss_ctl.k_ok  = ({1'b0, i_r} < (IW + 1)'(BUF));
        iss_ctl.v_ok  = ({1'b0, j_r} < (IW + 1)'(BUF));
        if (row_end) begin
          i_nxt    = '0;
          j_nxt    = j_r + 1'b1;
          addr_nxt = SW'(j_r) + 1'b1;
          if (j_r == IW'(DIM - 1)) begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          i_nxt    = i_r + 1'b1;
          addr_nxt = addr_r + SW'(DIM);
        end
      end
      ST_DRAIN: begin
        if (!dp_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy     = (state_r != ST_IDLE);
  assign iss_j    = j_r;
  assign iss_addr = addr_r;
  assign row_addr = i_r[BW-1:0];
  assign col_addr = j_r[BW-1:0];

endmodule

// ===== src/gla_dp.sv =====
// Datapath: decay and update of one state cell, then its share of the output sum.
`timescale 1ns / 1ps
module gla_dp #(
  parameter int DIM = gla_pkg::DIM_DEF,
  localparam int EMIT_N = (DIM < gla_pkg::MAX_OUT) ? DIM : gla_pkg::MAX_OUT,
  localparam int IW = $clog2(DIM),
  localparam int SW = $clog2(DIM * DIM)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [gla_pkg::GATE_W-1:0]    gate,
  input  logic [gla_pkg::SCALE_W-1:0]   scale,
  input  gla_pkg::cell_ctl_t            iss_ctl,
  input  logic [IW-1:0]                 iss_j,
  input  logic [SW-1:0]                 iss_addr,
  input  logic [gla_pkg::STATE_W-1:0]   s_rd,
  input  logic [gla_pkg::ELEM_W-1:0]    k_rd,
  input  logic [gla_pkg::ELEM_W-1:0]    q_rd,
  input  logic [gla_pkg::ELEM_W-1:0]    v_rd,
  output logic                          s_we,
  output logic [SW-1:0]                 s_waddr,
  output logic [gla_pkg::STATE_W-1:0]   s_wdata,
  output logic                          push_v,
  output logic [IW-1:0]                 push_j,
  output logic [gla_pkg::OUT_W-1:0]     push_val,
  output logic                          busy
);
  import gla_pkg::*;

  cell_ctl_t c1_r, c2_r, c3_r, c4_r, c5_r;
  logic [IW-1:0] j1_r, j2_r, j3_r, j4_r, j5_r, fin_j_r;
  logic [SW-1:0] a1_r, a2_r, a3_r;
  logic          fin_v_r;

  logic [STATE_W-1:0]   s_use;
  logic signed [15:0]   k_use, q_use, v_use;
  logic signed [41:0]   phi2_r;
  logic [32:0]          plo2_r;
  logic signed [31:0]   kv2_r;
  logic signed [32:0]   qsc2_r;
  logic [33:0]          plo_rnd;
  logic signed [42:0]   d_sum;
  logic signed [33:0]   q_rnd;
  logic [STATE_W-1:0]   snew_nxt, snew3_r;
  logic signed [20:0]   qs3_r;
  logic signed [44:0]   mhi4_r;
  logic signed [37:0]   mlo4_r;
  logic signed [37:0]   mlo_rnd;
  logic signed [63:0]   term_nxt, term5_r;
  logic signed [63:0]   acc_r, acc_nxt, fin_acc_r;
  logic signed [63:0]   out_rnd;

  // Control tags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r    <= '0;
      c2_r    <= '0;
      c3_r    <= '0;
      c4_r    <= '0;
      c5_r    <= '0;
      fin_v_r <= 1'b0;
    end else begin
      c1_r    <= iss_ctl;
      c2_r    <= c1_r;
      c3_r    <= c2_r;
      c4_r    <= c3_r;
      c5_r    <= c4_r;
      fin_v_r <= c5_r.vld && c5_r.last;
    end
  end

  // Stage 1: memory data arrives; form the four products.
  always_comb begin
    s_use = c1_r.clr ? '0 : s_rd;
    k_use = c1_r.k_ok ? $signed(k_rd) : 16'sd0;
    q_use = c1_r.k_ok ? $signed(q_rd) : 16'sd0;
    v_use = c1_r.v_ok ? $signed(v_rd) : 16'sd0;
  end

  always_ff @(posedge clk) begin
    j1_r    <= iss_j;
    a1_r    <= iss_addr;
    j2_r    <= j1_r;
    a2_r    <= a1_r;
    j3_r    <= j2_r;
    a3_r    <= a2_r;
    j4_r    <= j3_r;
    j5_r    <= j4_r;
    phi2_r  <= $signed(s_use[39:16]) * $signed({1'b0, gate});
    plo2_r  <= 33'(s_use[15:0]) * 33'(gate);
    kv2_r   <= k_use * v_use;
    qsc2_r  <= q_use * $signed({1'b0, scale});
  end

  // Stage 2: high product plus rounded low part plus key times value, saturated; scaled query rounded.
  always_comb begin
    plo_rnd = 34'(plo2_r) + 34'd32768;
    d_sum   = 43'(phi2_r) + 43'(plo_rnd[33:16]) + 43'(kv2_r);
    if (d_sum[42:39] == {4{d_sum[39]}}) begin
      snew_nxt = d_sum[39:0];
    end else if (d_sum[42]) begin
      snew_nxt = {1'b1, {(STATE_W - 1){1'b0}}};
    end else begin
      snew_nxt = {1'b0, {(STATE_W - 1){1'b1}}};
    end
    q_rnd = 34'(qsc2_r) + 34'sd2048;
  end

  always_ff @(posedge clk) begin
    snew3_r <= snew_nxt;
    qs3_r   <= q_rnd[32:12];
  end

  assign s_we    = c3_r.vld;
  assign s_waddr = a3_r;
  assign s_wdata = snew3_r;

  // Stage 3: scaled query times the new state, split into two products.
  always_ff @(posedge clk) begin
    mhi4_r <= qs3_r * $signed(snew3_r[39:16]);
    mlo4_r <= qs3_r * $signed({1'b0, snew3_r[15:0]});
  end

  // Stage 4: recombine and round to 24 fractional bits.
  always_comb begin
    mlo_rnd  = mlo4_r + 38'sd2048;
    term_nxt = (64'(mhi4_r) <<< 4) + 64'($signed(mlo_rnd[37:12]));
  end

  always_ff @(posedge clk) begin
    term5_r <= term_nxt;
  end

  // Stage 5: column accumulation; the column total is held for rounding.
  assign acc_nxt = (c5_r.first ? 64'sd0 : acc_r) + term5_r;

  always_ff @(posedge clk) begin
    if (c5_r.vld) begin
      acc_r <= acc_nxt;
    end
    fin_acc_r <= acc_nxt;
    fin_j_r   <= j5_r;
  end

  // Stage 6: round to 12 fractional bits and saturate to 32 bits.
  always_comb begin
    out_rnd = fin_acc_r + 64'sd2048;
    if (out_rnd[63:43] == {21{out_rnd[43]}}) begin
      push_val = out_rnd[43:12];
    end else if (out_rnd[63]) begin
      push_val = {1'b1, {(OUT_W - 1){1'b0}}};
    end else begin
      push_val = {1'b0, {(OUT_W - 1){1'b1}}};
    end
  end

  assign push_v = fin_v_r && ({1'b0, fin_j_r} < (IW + 1)'(EMIT_N));
  assign push_j = fin_j_r;
  assign busy   = c1_r.vld || c2_r.vld || c3_r.vld || c4_r.vld || c5_r.vld || fin_v_r;

endmodule

// ===== src/gla_chk.sv =====
// Port-level checker for the gated linear attention step, bound to the top level.
`timescale 1ns / 1ps
module gla_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_last,
  input logic [31:0] out_value
);

  // A waiting result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_value))
    else $error("result value changed while stalled");

  // After the last result of a token the queue is empty.
  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("result shown after the last result of a token");

  // A token's last element is taken only when no result is pending.
  a_last_in_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |-> !out_valid)
    else $error("last element taken while results pending");

  // The update pass blocks further input right after a last element.
  a_pass_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken during update pass");

endmodule

bind gated_linear_attention_step_top gla_chk u_gla_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .in_last(in_ch.last_elem), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_last(out_ch.out_last), .out_value(out_ch.out_value)
);

// ===== tb/tb_channels.sv =====
// Testbench-side notes: channel interfaces come from the RTL; this file holds shared tb types.
`timescale 1ns / 1ps
package tb_gla_types;
  typedef struct packed {
    logic [3:0]         elem_index;
    logic signed [15:0] query_elem;
    logic signed [15:0] key_elem;
    logic signed [15:0] value_elem;
    logic               last_elem;
    logic               seq_start;
  } elem_item_t;

  typedef struct packed {
    logic [3:0]         out_index;
    logic signed [31:0] out_value;
    logic               out_last;
  } attn_result_t;
endpackage

// ===== tb/tb.sv =====
// Self-checking testbench for the gated linear attention step with a fixed-point predictor.
`timescale 1ns / 1ps
module tb;
  import gla_pkg::*;
  import tb_gla_types::*;

  localparam int N = DIM_DEF;
  localparam int NEMIT = (N < MAX_OUT) ? N : MAX_OUT;
  localparam longint ST_HI = (64'sd1 <<< 39) - 1;
  localparam longint ST_LO = -(64'sd1 <<< 39);
  localparam longint LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  gla_in_if  in_ch();
  gla_out_if out_ch();
  gla_cfg_if cfg_ch();

  gated_linear_attention_step_top #(.DIM(N)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // Predictor state.
  logic [GATE_W-1:0]  gate_q;
  logic [SCALE_W-1:0] scale_q;
  longint q_buf[N], k_buf[N], v_buf[N];
  longint st_mat[N][N];

  elem_item_t   pending_items[$];
  attn_result_t expected_outputs[$];
  int errors = 0;
  longint cycle_count = 0;
  bit stim_done = 0;

  function automatic longint rnd_shift(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  task automatic predict_token(elem_item_t it);
    longint qs[N];
    longint acc;
    attn_result_t r;
    if (it.seq_start)
      foreach (st_mat[i, j]) st_mat[i][j] = 0;
    if (it.elem_index < N) begin
      q_buf[it.elem_index] = it.query_elem;
      k_buf[it.elem_index] = it.key_elem;
      v_buf[it.elem_index] = it.value_elem;
    end
    if (!it.last_elem) return;
    foreach (st_mat[i, j])
      st_mat[i][j] = clamp(rnd_shift(st_mat[i][j] * longint'(gate_q), 16)
                           + k_buf[i] * v_buf[j], ST_LO, ST_HI);
    for (int i = 0; i < N; i++) qs[i] = rnd_shift(q_buf[i] * longint'(scale_q), 12);
    for (int j = 0; j < NEMIT; j++) begin
      acc = 0;
      for (int i = 0; i < N; i++) acc += rnd_shift(qs[i] * st_mat[i][j], 12);
      r.out_index = 4'(j);
      r.out_value = 32'(clamp(rnd_shift(acc, 12), -64'sd2147483648, 64'sd2147483647));
      r.out_last  = (j == NEMIT - 1);
      expected_outputs.push_back(r);
    end
  endtask

  // Driver: bursts with random gaps; predictions are made on transfer.
  int gap_left = 0, burst_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_token(pending_items.pop_front());
      if (in_ch.valid && !in_ch.ready) begin
        // Hold the item until its transfer.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_ch.valid <= 1'b1;
        {in_ch.elem_index, in_ch.query_elem, in_ch.key_elem, in_ch.value_elem,
         in_ch.last_elem, in_ch.seq_start} <= pending_items[0];
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transfer and drives a stall pattern.
  int stall_mode = 0;
  always @(posedge clk) begin
    attn_result_t e;
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_outputs.size() == 0) begin
          $error("unexpected result index %0d value %0d", out_ch.out_index, out_ch.out_value);
          errors++;
        end else begin
          e = expected_outputs.pop_front();
          if (out_ch.out_index !== e.out_index) begin
            $error("out_index expected %0d actual %0d", e.out_index, out_ch.out_index);
            errors++;
          end
          if (out_ch.out_value !== e.out_value) begin
            $error("out_value expected %0d actual %0d", e.out_value, out_ch.out_value);
            errors++;
          end
          if (out_ch.out_last !== e.out_last) begin
            $error("out_last expected %0d actual %0d", e.out_last, out_ch.out_last);
            errors++;
          end
        end
      end
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= (cycle_count[3:0] < 4'd5);
      endcase
    end
  end

  always @(posedge clk) begin
    if (cycle_count > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic elem_item_t make_elem(int idx, bit last, bit start, int mode);
    elem_item_t it;
    it.elem_index = 4'(idx);
    it.last_elem  = last;
    it.seq_start  = start;
    case (mode)
      0: begin
        it.query_elem = 16'($urandom);
        it.key_elem   = 16'($urandom);
        it.value_elem = 16'($urandom);
      end
      1: begin
        // Moderate magnitudes keep the state off its rails.
        it.query_elem = 16'($urandom_range(0, 8191) - 4096);
        it.key_elem   = 16'($urandom_range(0, 8191) - 4096);
        it.value_elem = 16'($urandom_range(0, 8191) - 4096);
      end
      2: begin
        it.query_elem = 16'sh7fff; it.key_elem = 16'sh7fff; it.value_elem = 16'sh7fff;
      end
      default: begin
        it.query_elem = 16'sh8000; it.key_elem = 16'sh8000; it.value_elem = 16'sh7fff;
      end
    endcase
    return it;
  endfunction

  task automatic queue_token(bit start, int mode);
    for (int i = 0; i < N; i++)
      pending_items.push_back(make_elem(i, i == N - 1, (i == 0) && start, mode));
  endtask

  task automatic drain_all();
    while (pending_items.size() > 0 || in_ch.valid || expected_outputs.size() > 0)
      @(posedge clk);
    repeat (N * N + 40) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_DECAY_GATE) gate_q = val;
    else scale_q = val[SCALE_W-1:0];
    @(posedge clk);
  endtask

  initial begin
    elem_item_t it;
    int m;
    in_ch.valid = 0; in_ch.elem_index = 0; in_ch.query_elem = 0; in_ch.key_elem = 0;
    in_ch.value_elem = 0; in_ch.last_elem = 0; in_ch.seq_start = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0; cfg_ch.index = CFG_DECAY_GATE; cfg_ch.data = 0;
    gate_q = GATE_RST;
    scale_q = SCALE_RST;
    foreach (st_mat[i, j]) st_mat[i][j] = 0;
    foreach (q_buf[i]) begin
      q_buf[i] = 0; k_buf[i] = 0; v_buf[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one full token fills all buffers, then extremes and special cases.
    queue_token(1, 2);
    queue_token(0, 2);                       // full-scale inputs again, state kept
    pending_items.push_back(make_elem(3, 1, 0, 3));   // last alone; q, k at negative rail
    it = make_elem(5, 0, 1, 0);              // start without last
    pending_items.push_back(it);
    pending_items.push_back(make_elem(15, 1, 0, 1));
    drain_all();

    cfg_write(CFG_DECAY_GATE, 17'd0);
    cfg_write(CFG_QUERY_SCALE, 17'h0ffff);
    pending_items.push_back(make_elem(0, 1, 0, 2));
    pending_items.push_back(make_elem(1, 1, 0, 0));
    drain_all();
    cfg_write(CFG_DECAY_GATE, 17'h1ffff);    // gate above one
    cfg_write(CFG_QUERY_SCALE, 17'd0);
    pending_items.push_back(make_elem(2, 1, 0, 2));
    pending_items.push_back(make_elem(4, 1, 0, 3));
    drain_all();

    // Random phases with different settings.
    for (int ph = 0; ph < 4; ph++) begin
      cfg_write(CFG_DECAY_GATE, (ph == 3) ? 17'd65536 : 17'($urandom_range(0, 70000)));
      cfg_write(CFG_QUERY_SCALE, (ph == 3) ? 17'd4096 : 17'($urandom_range(0, 65535)));
      for (int t = 0; t < 26; t++) begin
        m = $urandom_range(0, 9);
        if (m < 5) begin
          // Short token: up to three updates then last.
          repeat ($urandom_range(0, 3))
            pending_items.push_back(make_elem($urandom_range(0, 15), 0,
                                              $urandom_range(0, 9) == 0, m % 2));
          pending_items.push_back(make_elem($urandom_range(0, 15), 1,
                                            $urandom_range(0, 5) == 0, m % 2));
        end else begin
          pending_items.push_back(make_elem($urandom_range(0, 15),
                                            $urandom_range(0, 3) == 0,
                                            $urandom_range(0, 7) == 0, m % 4));
        end
        if (pending_items.size() > 60) drain_all();
      end
      drain_all();
    end

    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ===== gated_linear_attention_step_top.f =====
src/gla_pkg.sv
src/gla_in_if.sv
src/gla_out_if.sv
src/gla_cfg_if.sv
src/gla_ram.sv
src/gla_seq.sv
src/gla_dp.sv
src/gated_linear_attention_step_top.sv
src/gla_chk.sv
tb/tb_channels.sv
tb/tb.sv
